// ----- src/rgbhsv_pkg.sv -----
`timescale 1ns / 1ps

package rgbhsv_pkg;

    // Defaults for the top level parameters.
    localparam int DEF_COMPONENT_BITS    = 8;
    localparam int DEF_HUE_FRACTION_BITS = 6;

    // Whole degrees of a full circle need nine bits (360 < 512).
    localparam int HUE_DEG_BITS = 9;

    // Sixty degrees fit in six bits of whole degrees (60 < 64).
    localparam int SIXTY_DEG_BITS = 6;

    localparam int SIXTY_DEG   = 60;
    localparam int FULL_CIRCLE = 360;

    // Which component holds the maximum; red is tested first, then green.
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

endpackage

// ----- src/rgb_to_hsv_converter.sv -----
`timescale 1ns / 1ps

// RGB to HSV converter, fully pipelined; a new pixel can enter in every cycle.
//
// A pixel is transferred in at a rising edge where start is high and busy is
// low. The pipeline never stalls, so busy is always low and a new pixel may
// be started in every cycle. Each pixel gives exactly one result: hue,
// saturation, value and achromatic are valid for exactly one cycle, marked by
// done, and are transferred at the edge that ends that cycle. The receiver
// cannot hold results off, so no back pressure reaches the pipeline.
//
// The pipeline stages, in order: one stage finds maximum, minimum and
// sector, one forms the two dividends, one stage per quotient bit runs the
// two restoring dividers side by side, and one stage forms the hue and
// registers the outputs.
//
// Reset clears all valid bits, so no result is presented after reset until
// a new pixel has gone through. Results keep the order of the pixels.
module rgb_to_hsv_converter #(
    parameter int COMPONENT_BITS    = rgbhsv_pkg::DEF_COMPONENT_BITS,
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::DEF_HUE_FRACTION_BITS
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    output logic                                               busy,
    input  logic [COMPONENT_BITS-1:0]                          red,
    input  logic [COMPONENT_BITS-1:0]                          green,
    input  logic [COMPONENT_BITS-1:0]                          blue,
    output logic                                               done,
    output logic [rgbhsv_pkg::HUE_DEG_BITS+HUE_FRACTION_BITS-1:0] hue,
    output logic [COMPONENT_BITS-1:0]                          saturation,
    output logic [COMPONENT_BITS-1:0]                          value,
    output logic                                               achromatic
);

    import rgbhsv_pkg::*;

    localparam int CB   = COMPONENT_BITS;
    localparam int HW   = HUE_DEG_BITS + HUE_FRACTION_BITS;
    // Width of the hue quotient: it never exceeds sixty degrees.
    localparam int QHW  = SIXTY_DEG_BITS + HUE_FRACTION_BITS;
    // Both dividers run the same number of steps so their results line up.
    localparam int NSTG = (CB > QHW) ? CB : QHW;
    // Dividend and partial remainder width.
    localparam int NW   = CB + NSTG;
    localparam int LAT  = NSTG + 3;

    localparam int SIXTY_UNITS = SIXTY_DEG << HUE_FRACTION_BITS;

    localparam logic [NW-1:0] SIXTY_NW   = NW'(SIXTY_UNITS);
    localparam logic [HW-1:0] HUE_120    = HW'(2 * SIXTY_UNITS);
    localparam logic [HW-1:0] HUE_240    = HW'(4 * SIXTY_UNITS);
    localparam logic [HW-1:0] HUE_FULL   = HW'(FULL_CIRCLE << HUE_FRACTION_BITS);

    // ------------------------------------------------------------------
    // Stage 1: maximum, minimum, spread, sector and signed difference.
    // ------------------------------------------------------------------
    logic [CB-1:0] rg_max;
    logic [CB-1:0] rg_min;
    logic [CB-1:0] max_next;
    logic [CB-1:0] min_next;
    sector_t       sector_next;
    logic [CB-1:0] opa;
    logic [CB-1:0] opb;
    logic          neg_next;
    logic [CB-1:0] diff_next;

    always_comb
    begin
        rg_max   = (red >= green) ? red : green;
        rg_min   = (red <= green) ? red : green;
        max_next = (blue > rg_max) ? blue : rg_max;
        min_next = (blue < rg_min) ? blue : rg_min;

        // The sector decides which pair of components forms the difference.
        if (red >= max_next)
        begin
            sector_next = SECT_RED;
            opa         = green;
            opb         = blue;
        end
        else if (green >= max_next)
        begin
            sector_next = SECT_GREEN;
            opa         = blue;
            opb         = red;
        end
        else
        begin
            sector_next = SECT_BLUE;
            opa         = red;
            opb         = green;
        end

        neg_next  = (opa < opb);
        diff_next = neg_next ? (opb - opa) : (opa - opb);
    end

    logic          s1_valid_reg;
    logic [CB-1:0] s1_max_reg;
    logic [CB-1:0] s1_spread_reg;
    logic [CB-1:0] s1_diff_reg;
    logic          s1_neg_reg;
    sector_t       s1_sector_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_max_reg    <= max_next;
        s1_spread_reg <= max_next - min_next;
        s1_diff_reg   <= diff_next;
        s1_neg_reg    <= neg_next;
        s1_sector_reg <= sector_next;
    end

    // ------------------------------------------------------------------
    // Divider pipeline. Index 0 holds the dividends; each later index has
    // resolved one more quotient bit, most significant first.
    // Saturation: (2^CB - 1) * spread / max.
    // Hue:        sixty degrees * difference / spread.
    // ------------------------------------------------------------------
    logic            dv_valid_reg  [0:NSTG];
    logic [NW-1:0]   sat_rem_reg   [0:NSTG];
    logic [NW-1:0]   hue_rem_reg   [0:NSTG];
    logic [NSTG-1:0] sat_q_reg     [0:NSTG];
    logic [NSTG-1:0] hue_q_reg     [0:NSTG];
    logic [CB-1:0]   max_reg       [0:NSTG];
    logic [CB-1:0]   spread_reg    [0:NSTG];
    logic            neg_reg       [0:NSTG];
    sector_t         sector_reg    [0:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Multiplying by 2^CB - 1 is a shift and a subtract.
        sat_rem_reg[0] <= (NW'(s1_spread_reg) << CB) - NW'(s1_spread_reg);
        hue_rem_reg[0] <= NW'(s1_diff_reg) * SIXTY_NW;
        sat_q_reg[0]   <= '0;
        hue_q_reg[0]   <= '0;
        max_reg[0]     <= s1_max_reg;
        spread_reg[0]  <= s1_spread_reg;
        neg_reg[0]     <= s1_neg_reg;
        sector_reg[0]  <= s1_sector_reg;
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        localparam int QBIT = NSTG - 1 - k;

        logic [NW-1:0]   sat_trial;
        logic [NW-1:0]   hue_trial;
        logic            sat_take;
        logic            hue_take;
        logic [NW-1:0]   sat_rem_next;
        logic [NW-1:0]   hue_rem_next;
        logic [NSTG-1:0] sat_q_next;
        logic [NSTG-1:0] hue_q_next;

        always_comb
        begin
            sat_trial    = NW'(max_reg[k]) << QBIT;
            hue_trial    = NW'(spread_reg[k]) << QBIT;
            sat_take     = (sat_rem_reg[k] >= sat_trial);
            hue_take     = (hue_rem_reg[k] >= hue_trial);
            sat_rem_next = sat_take ? (sat_rem_reg[k] - sat_trial) : sat_rem_reg[k];
            hue_rem_next = hue_take ? (hue_rem_reg[k] - hue_trial) : hue_rem_reg[k];
            sat_q_next   = sat_q_reg[k] | (NSTG'(sat_take) << QBIT);
            hue_q_next   = hue_q_reg[k] | (NSTG'(hue_take) << QBIT);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sat_rem_reg[k+1] <= sat_rem_next;
            hue_rem_reg[k+1] <= hue_rem_next;
            sat_q_reg[k+1]   <= sat_q_next;
            hue_q_reg[k+1]   <= hue_q_next;
            max_reg[k+1]     <= max_reg[k];
            spread_reg[k+1]  <= spread_reg[k];
            neg_reg[k+1]     <= neg_reg[k];
            sector_reg[k+1]  <= sector_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sector offset, sign of the difference and wrap-around.
    // ------------------------------------------------------------------
    logic [HW-1:0] hue_q;
    logic [HW-1:0] hue_next;
    logic          achrom_next;

    always_comb
    begin
        hue_q       = HW'(hue_q_reg[NSTG][QHW-1:0]);
        achrom_next = (spread_reg[NSTG] == '0);

        case (sector_reg[NSTG])
            SECT_RED:
            begin
                // A negative hue wraps by a full circle; minus zero stays zero.
                if (neg_reg[NSTG] && (hue_q != '0))
                begin
                    hue_next = HUE_FULL - hue_q;
                end
                else if (neg_reg[NSTG])
                begin
                    hue_next = '0;
                end
                else
                begin
                    hue_next = hue_q;
                end
            end
            SECT_GREEN:
            begin
                hue_next = neg_reg[NSTG] ? (HUE_120 - hue_q) : (HUE_120 + hue_q);
            end
            SECT_BLUE:
            begin
                hue_next = neg_reg[NSTG] ? (HUE_240 - hue_q) : (HUE_240 + hue_q);
            end
            default:
            begin
                hue_next = '0;
            end
        endcase

        if (achrom_next)
        begin
            hue_next = '0;
        end
    end

    logic          done_reg;
    logic [HW-1:0] hue_reg;
    logic [CB-1:0] sat_reg;
    logic [CB-1:0] value_reg;
    logic          achrom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= achrom_next ? '0 : sat_q_reg[NSTG][CB-1:0];
        value_reg  <= max_reg[NSTG];
        achrom_reg <= achrom_next;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;
    assign achromatic = achrom_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every result comes from a pixel that was started earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching start");

    // A gray pixel reports zero hue and zero saturation.
    a_achrom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && achromatic) |-> ((hue == '0) && (saturation == '0)))
        else $error("achromatic result with nonzero hue or saturation");

    // A colored pixel has a nonzero maximum and at least the smallest saturation.
    a_chroma_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !achromatic) |-> ((saturation != '0) && (value != '0)))
        else $error("colored result with zero saturation or value");

    // Hue stays below a full circle.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue < HUE_FULL))
        else $error("hue outside a full circle");

    // The saturation divider leaves a remainder below its divisor.
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[NSTG] && (spread_reg[NSTG] != '0))
            |-> (sat_rem_reg[NSTG] < NW'(max_reg[NSTG])))
        else $error("saturation divider did not converge");

endmodule
